// ===== hw/rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Types and codes shared by the sorted timer queue and its cells.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int ACTION_W = 2;
	localparam int HANDLE_W = 8;
	localparam int EXPIRE_W = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_ADJUST = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		logic                valid;
		logic [HANDLE_W-1:0] handle;
		logic [EXPIRE_W-1:0] expire;
	} entry_t;

	typedef struct packed {
		logic                ins;
		logic                rem;
		logic [HANDLE_W-1:0] handle;
		logic [EXPIRE_W-1:0] expire;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/stq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds one entry, shifts toward the tail on
// insert and toward the head on removal.
// ----------------------------------------------------------------------------
module stq_cell
	import stq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  entry_t    prev_entry,
	input  logic      prev_gt,
	input  entry_t    next_entry,
	input  logic      hit_in,
	output logic      gt,
	output logic      hit_out,
	output entry_t    entry_q,
	output entry_t    entry_d
);

	logic                match;
	logic                valid_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [EXPIRE_W-1:0] expire_q;

	assign entry_q = {valid_q, handle_q, expire_q};

	assign gt      = !entry_q.valid || (entry_q.expire > cmd.expire);
	assign match   = entry_q.valid && (entry_q.handle == cmd.handle);
	assign hit_out = hit_in || match;

	always_comb begin
		entry_d = entry_q;
		priority if (cmd.ins) begin
			if (gt) begin
				if (prev_gt) begin
					entry_d = prev_entry;
				end else begin
					entry_d.valid  = 1'b1;
					entry_d.handle = cmd.handle;
					entry_d.expire = cmd.expire;
				end
			end
		end else if (cmd.rem) begin
			if (hit_out) begin
				entry_d = next_entry;
			end
		end else begin
			entry_d = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		handle_q <= entry_d.handle;
		expire_q <= entry_d.expire;
	end

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Bounded timer queue kept in ascending expiry order in a row of cells.
// ----------------------------------------------------------------------------
// Entries live in a chain of QUEUE_DEPTH cells, earliest expiry in cell 0.
// Every cell compares its entry with the broadcast key in the same cycle and
// takes its own, its left or its right neighbor's entry or the key, so an
// insert or a delete updates the cells in the cycle it is taken; an adjust
// that finds its handle is a removal, then an insertion of the held key.
// The input is taken again once that work is done and the result register
// is free or being read. Each transfer yields one result with the head, the
// count and a status; the handle search ripples one gate per cell along the
// chain, which sets the clock for deep queues. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [EXPIRE_W-1:0] expire_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                head_valid,
	output logic [HANDLE_W-1:0] head_handle,
	output logic [EXPIRE_W-1:0] head_expire,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [STATUS_W-1:0] status
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_REINS = 2'b10
	} state_t;

	state_t              state_q, state_d;
	logic [OCC_W-1:0]    occ_q, occ_d;
	logic [HANDLE_W-1:0] key_handle_q;
	logic [EXPIRE_W-1:0] key_expire_q;
	logic                out_valid_q;
	logic                head_valid_q;
	logic [HANDLE_W-1:0] head_handle_q;
	logic [EXPIRE_W-1:0] head_expire_q;
	logic [COUNT_W-1:0]  count_q;
	status_t             status_q, status_d;

	cell_cmd_t cmd;
	logic      in_xfer, full, found, out_load;
	logic      is_ins, is_del, is_adj;

	entry_t cell_q [QUEUE_DEPTH];
	entry_t cell_d [QUEUE_DEPTH];
	logic   cell_gt  [QUEUE_DEPTH];
	logic   cell_hit [QUEUE_DEPTH];

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer  = in_valid && in_ready;
	assign full     = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign is_ins   = (action == ACT_INSERT);
	assign is_del   = (action == ACT_DELETE);
	assign is_adj   = (action == ACT_ADJUST);
	assign found    = cell_hit[QUEUE_DEPTH-1];

	always_comb begin
		cmd = '0;
		priority if (state_q == S_REINS) begin
			cmd.ins    = 1'b1;
			cmd.handle = key_handle_q;
			cmd.expire = key_expire_q;
		end else if (in_xfer) begin
			cmd.ins    = is_ins && !full;
			cmd.rem    = is_del || is_adj;
			cmd.handle = handle;
			cmd.expire = expire_time;
		end else begin
			cmd = '0;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_g, hit_i;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
			assign hit_i  = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_q[i-1];
			assign prev_g = cell_gt[i-1];
			assign hit_i  = cell_hit[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_q[i+1];
		end
		stq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev_e),
			.prev_gt    (prev_g),
			.next_entry (next_e),
			.hit_in     (hit_i),
			.gt         (cell_gt[i]),
			.hit_out    (cell_hit[i]),
			.entry_q    (cell_q[i]),
			.entry_d    (cell_d[i])
		);
	end

	always_comb begin
		occ_d    = occ_q;
		state_d  = state_q;
		status_d = ST_DONE;
		out_load = 1'b0;
		unique case (state_q)
			S_REINS: begin
				occ_d    = occ_q + OCC_W'(1);
				state_d  = S_IDLE;
				out_load = 1'b1;
			end
			S_IDLE: begin
				if (in_xfer) begin
					out_load = 1'b1;
					if (is_ins) begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							occ_d = occ_q + OCC_W'(1);
						end
					end else if (is_del || is_adj) begin
						if (!found) begin
							status_d = ST_MISSING;
						end else begin
							occ_d = occ_q - OCC_W'(1);
							if (is_adj) begin
								state_d  = S_REINS;
								out_load = 1'b0;
							end
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_handle_q <= handle;
			key_expire_q <= expire_time;
		end
		if (out_load) begin
			head_valid_q  <= cell_d[0].valid;
			head_handle_q <= cell_d[0].valid ? cell_d[0].handle : '0;
			head_expire_q <= cell_d[0].valid ? cell_d[0].expire : '0;
			count_q       <= COUNT_W'(occ_d);
			status_q      <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign head_valid  = head_valid_q;
	assign head_handle = head_handle_q;
	assign head_expire = head_expire_q;
	assign entry_count = count_q;
	assign status      = status_q;

endmodule

// ===== hw/rtl/stq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker
	import stq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                head_valid,
	input logic [HANDLE_W-1:0] head_handle,
	input logic [EXPIRE_W-1:0] head_expire,
	input logic [COUNT_W-1:0]  entry_count,
	input logic [STATUS_W-1:0] status
);

	// pending input transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input valid dropped before transfer");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(entry_count) && $stable(head_handle) && $stable(head_expire))
		else $error("result changed while stalled");

	// empty head reads as zero
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !head_valid |-> head_handle == '0 && head_expire == '0)
		else $error("empty queue shows a head entry");

	// a nonzero count means a head exists
	a_count_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count != '0 |-> head_valid)
		else $error("count without head");

	// a dropped insert reports a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == COUNT_W'(QUEUE_DEPTH)
			&& head_valid)
		else $error("full status with wrong count");

endmodule

bind sorted_timer_queue stq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_stq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.head_valid  (head_valid),
	.head_handle (head_handle),
	.head_expire (head_expire),
	.entry_count (entry_count),
	.status      (status)
);

// ===== tb/tb_sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue
// Self-checking bench for the sorted timer queue. A short table of operations
// covers the empty queue, expiry and handle extremes, ties, repeated handles,
// missing handles and the unused action code. Random phases follow that fill,
// drain or mix the queue, so that it reaches full and empty many times. Each
// result is compared with its table row or with a behavioral model of the
// ordered entry list, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;
	import stq_pkg::*;

	localparam int DEPTH = 64;
	localparam int RANDOM_OPS = 1200;
	localparam int MAX_SHOWN = 10;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_t;

	typedef struct {
		logic [HANDLE_W-1:0] handle;
		logic [EXPIRE_W-1:0] expire;
	} timer_t;

	typedef struct {
		logic                head_valid;
		logic [HANDLE_W-1:0] head_handle;
		logic [EXPIRE_W-1:0] head_expire;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} report_t;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [HANDLE_W-1:0] handle;
		logic [EXPIRE_W-1:0] expire;
		bit                  typed;
		report_t             report;
	} op_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [ACTION_W-1:0] action;
	logic [HANDLE_W-1:0] handle;
	logic [EXPIRE_W-1:0] expire_time;
	logic                out_valid;
	logic                out_ready;
	logic                head_valid;
	logic [HANDLE_W-1:0] head_handle;
	logic [EXPIRE_W-1:0] head_expire;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	timer_t  timers[$];
	report_t queued_reports[$];
	op_row_t dir_rows[$];
	int      failures;
	bit      tx_quiet;

	sorted_timer_queue #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.handle(handle),
		.expire_time(expire_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head_valid(head_valid),
		.head_handle(head_handle),
		.head_expire(head_expire),
		.entry_count(entry_count),
		.status(status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit place_timer(logic [HANDLE_W-1:0] h, logic [EXPIRE_W-1:0] e);
		timer_t t;
		int pos;
		if (timers.size() >= DEPTH)
			return 1'b0;
		pos = 0;
		while (pos < timers.size() && timers[pos].expire <= e)
			pos++;
		t.handle = h;
		t.expire = e;
		timers.insert(pos, t);
		return 1'b1;
	endfunction

	function automatic bit remove_timer(logic [HANDLE_W-1:0] h);
		int pos;
		pos = 0;
		while (pos < timers.size() && timers[pos].handle != h)
			pos++;
		if (pos >= timers.size())
			return 1'b0;
		timers.delete(pos);
		return 1'b1;
	endfunction

	function automatic report_t apply_timer_op(logic [ACTION_W-1:0] act,
			logic [HANDLE_W-1:0] h, logic [EXPIRE_W-1:0] e);
		report_t r;
		r.status = ST_DONE;
		case (act)
			ACT_INSERT: begin
				if (!place_timer(h, e))
					r.status = ST_FULL;
			end
			ACT_DELETE: begin
				if (!remove_timer(h))
					r.status = ST_MISSING;
			end
			ACT_ADJUST: begin
				if (remove_timer(h))
					void'(place_timer(h, e));
				else
					r.status = ST_MISSING;
			end
			default: ;
		endcase
		r.head_valid  = (timers.size() > 0);
		r.head_handle = r.head_valid ? timers[0].handle : '0;
		r.head_expire = r.head_valid ? timers[0].expire : '0;
		r.entry_count = COUNT_W'(timers.size());
		return r;
	endfunction

	task automatic add_row(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] h,
			input logic [EXPIRE_W-1:0] e, input bit typed, input logic hv,
			input logic [HANDLE_W-1:0] hh, input logic [EXPIRE_W-1:0] he,
			input logic [COUNT_W-1:0] cnt, input logic [STATUS_W-1:0] st);
		op_row_t row;
		row.action = act;
		row.handle = h;
		row.expire = e;
		row.typed  = typed;
		row.report.head_valid  = hv;
		row.report.head_handle = hh;
		row.report.head_expire = he;
		row.report.entry_count = cnt;
		row.report.status      = st;
		dir_rows.push_back(row);
	endtask

	function automatic op_row_t random_op(load_mode_t mode);
		op_row_t op;
		int pick;
		int ins_lim;
		int del_lim;
		pick    = $urandom_range(0, 99);
		ins_lim = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 15 : 40;
		del_lim = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 75 : 70;
		if (pick < ins_lim)
			op.action = ACT_INSERT;
		else if (pick < del_lim)
			op.action = ACT_DELETE;
		else if (pick < 99)
			op.action = ACT_ADJUST;
		else
			op.action = ACT_UNUSED;

		pick = $urandom_range(0, 9);
		if (pick < 6 && timers.size() > 0)
			op.handle = timers[$urandom_range(0, timers.size() - 1)].handle;
		else if (pick < 8)
			op.handle = HANDLE_W'($urandom_range(0, 15));
		else
			op.handle = HANDLE_W'($urandom_range(0, 255));

		pick = $urandom_range(0, 9);
		if (pick < 4)
			op.expire = $urandom_range(0, 63);
		else if (pick < 8)
			op.expire = $urandom();
		else if (pick == 8)
			op.expire = $urandom_range(0, 1) ? '1 : '0;
		else if (timers.size() > 0)
			op.expire = timers[$urandom_range(0, timers.size() - 1)].expire;
		else
			op.expire = $urandom();
		op.typed = 1'b0;
		return op;
	endfunction

	task automatic send_op(input op_row_t op);
		int gap;
		report_t r;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= op.action;
		handle      <= op.handle;
		expire_time <= op.expire;
		do @(posedge clk); while (!in_ready);
		r = apply_timer_op(op.action, op.handle, op.expire);
		queued_reports.push_back(op.typed ? op.report : r);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		do @(posedge clk); while (queued_reports.size() != 0);
	endtask

	// result side: check each transfer, then stall at random unless in a quiet stretch
	initial begin
		int stall;
		int seen;
		bit rx_quiet;
		report_t want;
		stall     = 0;
		seen      = 0;
		rx_quiet  = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (queued_reports.size() == 0) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("unexpected transfer: valid %b handle %h expire %h %s %0d %0d",
							head_valid, head_handle, head_expire, "count/status",
							entry_count, status);
				end else begin
					want = queued_reports.pop_front();
					if (want.head_valid !== head_valid || want.head_handle !== head_handle ||
							want.head_expire !== head_expire ||
							want.entry_count !== entry_count || want.status !== status) begin
						failures++;
						if (failures <= MAX_SHOWN) begin
							$display("mismatch: expected valid %b handle %h expire %h count %0d status %0d",
								want.head_valid, want.head_handle, want.head_expire,
								want.entry_count, want.status);
							$display("          actual   valid %b handle %h expire %h count %0d status %0d",
								head_valid, head_handle, head_expire, entry_count, status);
						end
					end
				end
				seen++;
				if (seen % 50 == 0)
					rx_quiet = ($urandom_range(0, 3) == 0);
				stall = rx_quiet ? 0 : $urandom_range(0, 15);
			end else if (stall > 0) begin
				stall--;
			end
			out_ready <= (stall == 0);
		end
	end

	initial begin
		op_row_t op;
		int sent;
		int phase_len;
		load_mode_t mode;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_INSERT;
		handle      = '0;
		expire_time = '0;
		failures    = 0;
		tx_quiet    = 1'b0;

		// empty queue, unused code, extremes, ties and repeated handles
		add_row(ACT_DELETE, 8'd5, 32'd0, 1, 0, 8'h00, 32'h0, 0, ST_MISSING);
		add_row(ACT_ADJUST, 8'd5, 32'd9, 1, 0, 8'h00, 32'h0, 0, ST_MISSING);
		add_row(ACT_UNUSED, 8'd5, 32'd9, 1, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_INSERT, 8'h00, 32'hFFFF_FFFF, 1, 1, 8'h00, 32'hFFFF_FFFF, 1, ST_DONE);
		add_row(ACT_INSERT, 8'hFF, 32'h0, 1, 1, 8'hFF, 32'h0, 2, ST_DONE);
		add_row(ACT_INSERT, 8'h07, 32'h0, 1, 1, 8'hFF, 32'h0, 3, ST_DONE);
		add_row(ACT_INSERT, 8'hFF, 32'd100, 1, 1, 8'hFF, 32'h0, 4, ST_DONE);
		add_row(ACT_DELETE, 8'hFF, 32'h0, 1, 1, 8'h07, 32'h0, 3, ST_DONE);
		add_row(ACT_ADJUST, 8'h07, 32'hFFFF_FFFF, 1, 1, 8'hFF, 32'd100, 3, ST_DONE);
		add_row(ACT_ADJUST, 8'h00, 32'h0, 1, 1, 8'h00, 32'h0, 3, ST_DONE);
		add_row(ACT_UNUSED, 8'h00, 32'h0, 1, 1, 8'h00, 32'h0, 3, ST_DONE);
		add_row(ACT_DELETE, 8'd200, 32'h0, 1, 1, 8'h00, 32'h0, 3, ST_MISSING);
		add_row(ACT_INSERT, 8'hAA, 32'h5555_5555, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_INSERT, 8'h55, 32'hAAAA_AAAA, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_ADJUST, 8'h55, 32'd50, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'h00, 32'h0, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'hFF, 32'h0, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'h07, 32'h0, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'hAA, 32'h0, 0, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'h55, 32'h0, 1, 0, 8'h00, 32'h0, 0, ST_DONE);
		add_row(ACT_DELETE, 8'h55, 32'h0, 1, 0, 8'h00, 32'h0, 0, ST_MISSING);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_op(dir_rows[i]);
		drain_wait();

		// first phase fills past full, later phases pick a load mix at random
		sent      = 0;
		mode      = MODE_FILL;
		phase_len = 120;
		while (sent < RANDOM_OPS) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				op = random_op(mode);
				send_op(op);
				if (op.action != ACT_UNUSED)
					sent++;
			end
			drain_wait();
			mode      = load_mode_t'($urandom_range(0, 2));
			phase_len = $urandom_range(40, 160);
		end

		repeat (20) @(posedge clk);
		failures += queued_reports.size();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue.sv
hw/rtl/stq_checker.sv
tb/tb_sorted_timer_queue.sv
